// ===== hw/rtl/rational_tick_divider_with_stall_watch_top_defines.svh =====
// Assertion macros shared by the rational tick divider RTL files.
`ifndef RATIONAL_TICK_DIVIDER_WITH_STALL_WATCH_TOP_DEFINES_SVH
`define RATIONAL_TICK_DIVIDER_WITH_STALL_WATCH_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle during rst.
`define RTD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, idle during rst.
`define RTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rtd_pkg.sv =====
// Shared types, codes and constants of the rational tick divider.
`default_nettype none
package rtd_pkg;

  localparam int RATE_W   = 31;
  localparam int THRESH_W = 16;
  localparam int ELAPSED_W = 16;
  localparam int WORD_W   = 32;
  localparam int PROD_W   = RATE_W + ELAPSED_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int DIV_STEPS = ELAPSED_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int ADDR_W   = 4;

  localparam logic [RATE_W-1:0]   INPUT_RATE_RST   = 31'd44100;
  localparam logic [RATE_W-1:0]   SERVICE_RATE_RST = 31'd60;
  localparam logic [THRESH_W-1:0] STALL_THRESH_RST = 16'd16;

  localparam logic [WORD_W-1:0] HALF_RANGE = 32'h8000_0000;

  // operation codes
  localparam logic [1:0] OP_ADVANCE = 2'd0;
  localparam logic [1:0] OP_OBSERVE = 2'd1;
  localparam logic [1:0] OP_CLAIM   = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_INPUT_RATE   = 2'd0;
  localparam logic [1:0] REG_SERVICE_RATE = 2'd1;
  localparam logic [1:0] REG_STALL_THRESH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic add;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic adv_go;
    logic div_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rtd_ctrl.sv =====
// Sequencer for the rational tick divider: handshakes and step commands.
`default_nettype none
`include "rational_tick_divider_with_stall_watch_top_defines.svh"
module rtd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  rtd_pkg::sts_t sts,
  output rtd_pkg::cmd_t cmd
);

  rtd_pkg::state_t state;
  rtd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      rtd_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = rtd_pkg::ST_CHECK;
        end
      end
      rtd_pkg::ST_CHECK: begin
        state_next = sts.adv_go ? rtd_pkg::ST_MUL : rtd_pkg::ST_FINISH;
      end
      rtd_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = rtd_pkg::ST_ADD;
      end
      rtd_pkg::ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = rtd_pkg::ST_DIV;
      end
      rtd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = rtd_pkg::ST_FINISH;
        end
      end
      rtd_pkg::ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.commit = 1'b1;
          state_next = rtd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rtd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `RTD_ASSERT_SAME(a_commit_no_overwrite, cmd.commit && out_valid, !out_stall,
    "result overwritten while still stalled")
  `RTD_ASSERT_SAME(a_out_from_commit, $rose(out_valid), $past(cmd.commit),
    "output valid rose without a commit")

endmodule
`default_nettype wire

// ===== hw/rtl/rtd_dp.sv =====
// Datapath: item registers, multiply, restoring divider, state and result.
`default_nettype none
`include "rational_tick_divider_with_stall_watch_top_defines.svh"
module rtd_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_clear,
  input  logic [rtd_pkg::RATE_W-1:0]     input_rate,
  input  logic [rtd_pkg::RATE_W-1:0]     service_rate,
  input  logic [rtd_pkg::THRESH_W-1:0]   stall_threshold,
  input  logic [1:0]                     op,
  input  logic [rtd_pkg::ELAPSED_W-1:0]  elapsed_ticks,
  input  logic [rtd_pkg::WORD_W-1:0]     hw_tick_value,
  input  logic [rtd_pkg::WORD_W-1:0]     generation_value,
  input  rtd_pkg::cmd_t                  cmd,
  output rtd_pkg::sts_t                  sts,
  output logic                           ok,
  output logic [rtd_pkg::ELAPSED_W-1:0]  service_due,
  output logic [rtd_pkg::WORD_W-1:0]     service_total,
  output logic                           stalled_flag,
  output logic [rtd_pkg::WORD_W-1:0]     stale_count
);

  // item registers
  logic [1:0]                    op_q;
  logic [rtd_pkg::ELAPSED_W-1:0] elapsed_q;
  logic [rtd_pkg::WORD_W-1:0]    hw_q;
  logic [rtd_pkg::WORD_W-1:0]    gen_q;

  // arithmetic registers
  logic [rtd_pkg::PROD_W-1:0]    prod;
  logic [rtd_pkg::RATE_W-1:0]    rem;
  logic [rtd_pkg::ELAPSED_W-1:0] quo;
  logic [rtd_pkg::DIV_CNT_W-1:0] cnt;

  // block state
  logic [rtd_pkg::RATE_W-1:0]    acc;
  logic [rtd_pkg::WORD_W-1:0]    svc_count;
  logic                          stall_latched;
  logic                          hw_seen;
  logic [rtd_pkg::WORD_W-1:0]    last_hw;
  logic [rtd_pkg::THRESH_W-1:0]  rep_count;
  logic                          gen_seen;
  logic [rtd_pkg::WORD_W-1:0]    last_gen;
  logic [rtd_pkg::WORD_W-1:0]    reject_count;

  logic [rtd_pkg::WORD_W-1:0]    svc_count_next;
  logic                          stall_latched_next;
  logic                          hw_seen_next;
  logic [rtd_pkg::WORD_W-1:0]    last_hw_next;
  logic [rtd_pkg::THRESH_W-1:0]  rep_count_next;
  logic                          gen_seen_next;
  logic [rtd_pkg::WORD_W-1:0]    last_gen_next;
  logic [rtd_pkg::WORD_W-1:0]    reject_count_next;
  logic                          ok_next;
  logic [rtd_pkg::ELAPSED_W-1:0] due_next;

  logic                          cfg_ok;
  logic [rtd_pkg::SUM_W-1:0]     sum;
  logic [rtd_pkg::WORD_W-1:0]    trial;
  logic [rtd_pkg::WORD_W-1:0]    diff;
  logic                          qbit;
  logic [rtd_pkg::THRESH_W-1:0]  rep_inc;
  logic [rtd_pkg::WORD_W-1:0]    gen_delta;

  assign cfg_ok = (input_rate != '0) && (service_rate != '0) &&
                  (service_rate <= input_rate) && (stall_threshold != '0);

  assign sts.adv_go = cfg_ok && (op_q == rtd_pkg::OP_ADVANCE) &&
                      (elapsed_q != '0) &&
                      (rtd_pkg::RATE_W'(elapsed_q) <= input_rate) && !stall_latched;
  assign sts.div_last = (cnt == rtd_pkg::DIV_CNT_W'(rtd_pkg::DIV_STEPS - 1));

  assign sum   = rtd_pkg::SUM_W'(prod) + rtd_pkg::SUM_W'(acc);
  assign trial = {rem, quo[rtd_pkg::ELAPSED_W-1]};
  assign qbit  = (trial >= {1'b0, input_rate});
  assign diff  = trial - {1'b0, input_rate};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= op;
      elapsed_q <= elapsed_ticks;
      hw_q      <= hw_tick_value;
      gen_q     <= generation_value;
    end
    if (cmd.mul) begin
      prod <= rtd_pkg::PROD_W'(elapsed_q) * rtd_pkg::PROD_W'(service_rate);
    end
    if (cmd.add) begin
      // high part is below the divisor, so the quotient fits the low part
      rem <= sum[rtd_pkg::SUM_W-2 -: rtd_pkg::RATE_W];
      quo <= sum[rtd_pkg::ELAPSED_W-1:0];
      cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= qbit ? diff[rtd_pkg::RATE_W-1:0] : trial[rtd_pkg::RATE_W-1:0];
      quo <= {quo[rtd_pkg::ELAPSED_W-2:0], qbit};
      cnt <= cnt + 1'b1;
    end
  end

  assign rep_inc   = rep_count + 1'b1;
  assign gen_delta = gen_q - last_gen;

  always_comb begin
    ok_next            = 1'b0;
    due_next           = '0;
    svc_count_next     = svc_count;
    stall_latched_next = stall_latched;
    hw_seen_next       = hw_seen;
    last_hw_next       = last_hw;
    rep_count_next     = rep_count;
    gen_seen_next      = gen_seen;
    last_gen_next      = last_gen;
    reject_count_next  = reject_count;
    if (cfg_ok) begin
      unique case (op_q)
        rtd_pkg::OP_ADVANCE: begin
          if (sts.adv_go) begin
            ok_next        = 1'b1;
            due_next       = quo;
            svc_count_next = svc_count + rtd_pkg::WORD_W'(quo);
          end
        end
        rtd_pkg::OP_OBSERVE: begin
          if (!stall_latched) begin
            if (!hw_seen || (hw_q != last_hw)) begin
              hw_seen_next   = 1'b1;
              last_hw_next   = hw_q;
              rep_count_next = '0;
              ok_next        = 1'b1;
            end else begin
              rep_count_next = rep_inc;
              if (rep_inc >= stall_threshold) begin
                stall_latched_next = 1'b1;
              end else begin
                ok_next = 1'b1;
              end
            end
          end
        end
        rtd_pkg::OP_CLAIM: begin
          if ((gen_q == '0) ||
              (gen_seen && ((gen_delta == '0) || (gen_delta >= rtd_pkg::HALF_RANGE)))) begin
            reject_count_next = reject_count + 1'b1;
          end else begin
            gen_seen_next = 1'b1;
            last_gen_next = gen_q;
            ok_next       = 1'b1;
          end
        end
        default: begin
          ok_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      acc           <= '0;
      svc_count     <= '0;
      stall_latched <= 1'b0;
      hw_seen       <= 1'b0;
      last_hw       <= '0;
      rep_count     <= '0;
      gen_seen      <= 1'b0;
      last_gen      <= '0;
      reject_count  <= '0;
    end else if (cmd.commit) begin
      if (sts.adv_go) begin
        acc <= rem;
      end
      svc_count     <= svc_count_next;
      stall_latched <= stall_latched_next;
      hw_seen       <= hw_seen_next;
      last_hw       <= last_hw_next;
      rep_count     <= rep_count_next;
      gen_seen      <= gen_seen_next;
      last_gen      <= last_gen_next;
      reject_count  <= reject_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ok            <= ok_next;
      service_due   <= due_next;
      service_total <= svc_count_next;
      stalled_flag  <= stall_latched_next;
      stale_count   <= reject_count_next;
    end
  end

  `RTD_ASSERT_SAME(a_quo_bounded, cmd.commit && sts.adv_go,
    rtd_pkg::ELAPSED_W'(quo) <= elapsed_q, "quotient exceeds elapsed count")
  `RTD_ASSERT_NEXT(a_rem_below_rate, cmd.commit && sts.adv_go && !cfg_clear,
    acc < input_rate, "remainder not below input rate")
  `RTD_ASSERT_NEXT(a_div_start, cmd.add, cnt == '0, "divider count not cleared")

endmodule
`default_nettype wire

// ===== hw/rtl/rational_tick_divider_with_stall_watch_top.sv =====
// Top level of the rational tick divider with stall watch: APB registers and wiring.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  op, elapsed_ticks, hw_tick_value,
//                                            generation_value
//   out      source     out_valid/out_stall  ok, service_due, service_total,
//                                            stalled_flag, stale_count
//   cfg      APB slave  psel/penable/pready  paddr, pwdata, prdata
//
// An advance goes from its transfer to its result register by these steps: a
// check, the 16x31 multiply, the 48-bit add, the restoring divider that retires
// one quotient bit per cycle for the 16-bit quotient, and the commit. Observe,
// claim and rejected ops go from the check straight to the commit. One item
// is in work at a time; the commit holds while an earlier result still waits
// under out_stall. in_stall drops again the cycle after the result is
// registered, even while out_stall holds that result. rst is synchronous and
// clears state and registers to defaults; a write to any listed register clears
// the block state as well.
`default_nettype none
module rational_tick_divider_with_stall_watch_top (
  input  logic                           clk,
  input  logic                           rst,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     op,
  input  logic [rtd_pkg::ELAPSED_W-1:0]  elapsed_ticks,
  input  logic [rtd_pkg::WORD_W-1:0]     hw_tick_value,
  input  logic [rtd_pkg::WORD_W-1:0]     generation_value,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           ok,
  output logic [rtd_pkg::ELAPSED_W-1:0]  service_due,
  output logic [rtd_pkg::WORD_W-1:0]     service_total,
  output logic                           stalled_flag,
  output logic [rtd_pkg::WORD_W-1:0]     stale_count,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rtd_pkg::ADDR_W-1:0]     paddr,
  input  logic [rtd_pkg::WORD_W-1:0]     pwdata,
  output logic [rtd_pkg::WORD_W-1:0]     prdata,
  output logic                           pready
);

  logic [rtd_pkg::RATE_W-1:0]   input_rate;
  logic [rtd_pkg::RATE_W-1:0]   service_rate;
  logic [rtd_pkg::THRESH_W-1:0] stall_threshold;

  logic       cfg_wr;
  logic       cfg_clear;
  logic [1:0] reg_index;

  rtd_pkg::cmd_t cmd;
  rtd_pkg::sts_t sts;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_wr    = psel && penable && pwrite;

  // Hold the register file; a write to a listed register also drops block state.
  always_ff @(posedge clk) begin
    if (rst) begin
      input_rate      <= rtd_pkg::INPUT_RATE_RST;
      service_rate    <= rtd_pkg::SERVICE_RATE_RST;
      stall_threshold <= rtd_pkg::STALL_THRESH_RST;
    end else if (cfg_wr) begin
      unique case (reg_index)
        rtd_pkg::REG_INPUT_RATE:   input_rate      <= pwdata[rtd_pkg::RATE_W-1:0];
        rtd_pkg::REG_SERVICE_RATE: service_rate    <= pwdata[rtd_pkg::RATE_W-1:0];
        rtd_pkg::REG_STALL_THRESH: stall_threshold <= pwdata[rtd_pkg::THRESH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg_clear = 1'b0;
    unique case (reg_index) inside
      rtd_pkg::REG_INPUT_RATE,
      rtd_pkg::REG_SERVICE_RATE,
      rtd_pkg::REG_STALL_THRESH: cfg_clear = cfg_wr;
      default: cfg_clear = 1'b0;
    endcase
  end

  // Read back zero-extended register values; unlisted addresses read as zero.
  always_comb begin
    unique case (reg_index)
      rtd_pkg::REG_INPUT_RATE:   prdata = rtd_pkg::WORD_W'(input_rate);
      rtd_pkg::REG_SERVICE_RATE: prdata = rtd_pkg::WORD_W'(service_rate);
      rtd_pkg::REG_STALL_THRESH: prdata = rtd_pkg::WORD_W'(stall_threshold);
      default:                   prdata = '0;
    endcase
  end

  rtd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rtd_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_clear        (cfg_clear),
    .input_rate       (input_rate),
    .service_rate     (service_rate),
    .stall_threshold  (stall_threshold),
    .op               (op),
    .elapsed_ticks    (elapsed_ticks),
    .hw_tick_value    (hw_tick_value),
    .generation_value (generation_value),
    .cmd              (cmd),
    .sts              (sts),
    .ok               (ok),
    .service_due      (service_due),
    .service_total    (service_total),
    .stalled_flag     (stalled_flag),
    .stale_count      (stale_count)
  );

endmodule
`default_nettype wire
